// ===== rtl/aasf_pkg.sv =====
// ----------------------------------------------------------------------------
// aasf_pkg
// Shared types and constants for the data-processing ALU with barrel shifter.
// ----------------------------------------------------------------------------
package aasf_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned FUNC_W  = 4;
    localparam int unsigned SHAMT_W = 5;

    // sideband and data widths on the stream ports
    localparam int unsigned S_TUSER_W = FUNC_W + 2;
    localparam int unsigned S_TDATA_W = 2 * DATA_W;
    localparam int unsigned M_TDATA_W = 40;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD = 4'd0,
        FN_ADC = 4'd1,
        FN_AND = 4'd2,
        FN_BIC = 4'd3,
        FN_EOR = 4'd4,
        FN_MOV = 4'd5,
        FN_MVN = 4'd6,
        FN_ORR = 4'd7,
        FN_SBC = 4'd8,
        FN_SUB = 4'd9,
        FN_LSL = 4'd10,
        FN_LSR = 4'd11,
        FN_ASR = 4'd12,
        FN_ROR = 4'd13,
        FN_MUL = 4'd14
    } func_t;

    // condition flags
    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } nzcv_t;

endpackage

// ===== rtl/arm_alu_shifter_flags.sv =====
// ----------------------------------------------------------------------------
// arm_alu_shifter_flags
// ARMv4-style data-processing ALU with barrel shifts, multiply and NZCV flags.
// ----------------------------------------------------------------------------
// One item carries an operation, two 32-bit operands and the flag and carry
// update bits; one result item comes back with the 32-bit value and the flags
// as they stand after the operation. Each item passes through the input register
// and then the result register, and a new item is taken every cycle while the
// output is free. The flags register is
// written as an item moves into the result register, so ADC and SBC see the
// carry of the item just before them. Reset clears all four flags. Code 15
// returns zero and leaves the flags alone.
module arm_alu_shifter_flags (
    input  logic                            clk,
    input  logic                            rst_n,
    // input item
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // operand_a [31:0], operand_b [63:32]
    input  logic [aasf_pkg::S_TDATA_W-1:0]  s_tdata,
    // func [3:0], update_flags [4], update_carry [5]
    input  logic [aasf_pkg::S_TUSER_W-1:0]  s_tuser,
    // result item
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // value [31:0], flag_n [32], flag_z [33], flag_c [34], flag_v [35], zeros above
    output logic [aasf_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int unsigned W = aasf_pkg::DATA_W;

    // input register
    logic                        in_valid_reg;
    logic [aasf_pkg::FUNC_W-1:0] func_reg;
    logic [W-1:0]                a_reg;
    logic [W-1:0]                b_reg;
    logic                        uf_reg;
    logic                        uc_reg;

    // result register and flag state
    logic                        out_valid_reg;
    logic [W-1:0]                value_reg;
    aasf_pkg::nzcv_t             flags_reg;
    aasf_pkg::nzcv_t             flags_next;
    logic [W-1:0]                value_next;

    logic advance;
    logic out_free;

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(aasf_pkg::M_TDATA_W - W - 4){1'b0}},
                       flags_reg.v, flags_reg.c, flags_reg.z, flags_reg.n, value_reg};

    // adder, shifter and multiplier
    logic            cin;
    logic            shc;
    logic            b_small;
    logic [4:0]      sh;
    logic [W:0]      add_sum;
    logic [W:0]      sub_sum;
    logic [W:0]      lsl_wide;
    logic [W:0]      lsr_wide;
    logic [W:0]      asr_wide;
    logic [2*W-1:0]  ror_wide;
    logic [W-1:0]    mul_lo;
    logic            c_res;
    logic            c_write;
    logic            v_res;
    logic            v_write;
    logic            nz_write;

    always_comb
    begin
        cin      = flags_reg.c;
        shc      = uf_reg && uc_reg;
        b_small  = (b_reg[W-1:aasf_pkg::SHAMT_W] == '0);
        sh       = b_reg[aasf_pkg::SHAMT_W-1:0];
        add_sum  = {1'b0, a_reg} + {1'b0, b_reg}
                   + {{W{1'b0}}, (func_reg == aasf_pkg::FN_ADC) && cin};
        sub_sum  = {1'b0, a_reg} + {1'b0, ~b_reg}
                   + {{W{1'b0}}, (func_reg == aasf_pkg::FN_SBC) ? cin : 1'b1};
        lsl_wide = {1'b0, a_reg} << sh;
        lsr_wide = {a_reg, 1'b0} >> sh;
        asr_wide = $signed({a_reg, 1'b0}) >>> sh;
        ror_wide = {a_reg, a_reg} >> sh;
        mul_lo   = W'(a_reg * b_reg);

        value_next = '0;
        c_res      = 1'b0;
        c_write    = 1'b0;
        v_res      = 1'b0;
        v_write    = 1'b0;
        nz_write   = uf_reg;

        case (func_reg) inside
            aasf_pkg::FN_ADD, aasf_pkg::FN_ADC:
            begin
                value_next = add_sum[W-1:0];
                c_res      = add_sum[W];
                c_write    = uf_reg;
                v_res      = ~(a_reg[W-1] ^ b_reg[W-1]) & (a_reg[W-1] ^ add_sum[W-1]);
                v_write    = uf_reg;
            end
            aasf_pkg::FN_SUB, aasf_pkg::FN_SBC:
            begin
                value_next = sub_sum[W-1:0];
                c_res      = sub_sum[W];
                c_write    = uf_reg;
                v_res      = (a_reg[W-1] ^ b_reg[W-1]) & (a_reg[W-1] ^ sub_sum[W-1]);
                v_write    = uf_reg;
            end
            aasf_pkg::FN_AND: value_next = a_reg & b_reg;
            aasf_pkg::FN_BIC: value_next = a_reg & ~b_reg;
            aasf_pkg::FN_EOR: value_next = a_reg ^ b_reg;
            aasf_pkg::FN_MOV: value_next = b_reg;
            aasf_pkg::FN_MVN: value_next = ~b_reg;
            aasf_pkg::FN_ORR: value_next = a_reg | b_reg;
            aasf_pkg::FN_MUL: value_next = mul_lo;
            aasf_pkg::FN_LSL:
            begin
                if (b_reg == '0)
                begin
                    value_next = a_reg;
                end
                else if (b_small)
                begin
                    value_next = lsl_wide[W-1:0];
                    c_res      = lsl_wide[W];
                    c_write    = shc;
                end
                else
                begin
                    // shifted out entirely: only a shift of exactly 32 moves bit 0 into carry
                    c_res   = (b_reg == W'(W)) && a_reg[0];
                    c_write = shc;
                end
            end
            aasf_pkg::FN_LSR:
            begin
                if (b_small && (sh != '0))
                begin
                    value_next = lsr_wide[W:1];
                    c_res      = lsr_wide[0];
                end
                else
                begin
                    // zero amount means 32
                    c_res = ((b_reg == '0) || (b_reg == W'(W))) && a_reg[W-1];
                end
                c_write = shc;
            end
            aasf_pkg::FN_ASR:
            begin
                if (b_small && (sh != '0))
                begin
                    value_next = asr_wide[W:1];
                    c_res      = asr_wide[0];
                end
                else
                begin
                    // zero or 32 and above: sign fill
                    value_next = {W{a_reg[W-1]}};
                    c_res      = a_reg[W-1];
                end
                c_write = shc;
            end
            aasf_pkg::FN_ROR:
            begin
                value_next = ror_wide[W-1:0];
                // last bit rotated out lands in bit 31, also for a full turn
                c_res      = ror_wide[W-1];
                c_write    = shc && (b_reg[7:0] != 8'd0);
            end
            default:
            begin
                value_next = '0;
                nz_write   = 1'b0;
            end
        endcase

        flags_next = flags_reg;
        if (nz_write)
        begin
            flags_next.n = value_next[W-1];
            flags_next.z = (value_next == '0);
        end
        if (c_write)
        begin
            flags_next.c = c_res;
        end
        if (v_write)
        begin
            flags_next.v = v_res;
        end
    end

    // control and flag state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg <= s_tuser[aasf_pkg::FUNC_W-1:0];
            uf_reg   <= s_tuser[aasf_pkg::FUNC_W];
            uc_reg   <= s_tuser[aasf_pkg::FUNC_W+1];
            a_reg    <= s_tdata[W-1:0];
            b_reg    <= s_tdata[2*W-1:W];
        end
        if (advance)
        begin
            value_reg <= value_next;
        end
    end

endmodule

// ===== rtl/aasf_checker.sv =====
// ----------------------------------------------------------------------------
// aasf_checker
// Port-level checks for the ALU stream interface, bound to the top level.
// ----------------------------------------------------------------------------
module aasf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [aasf_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic [aasf_pkg::S_TUSER_W-1:0]  s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [aasf_pkg::M_TDATA_W-1:0]  m_tdata
);

    // a stalled result holds its value and flags
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a free output never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    // an accepted item moves on from the input register to the output when the output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 (m_tready || !m_tvalid) |=> m_tvalid)
        else $error("accepted item did not reach the output");

    // padding bits above the flags stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[aasf_pkg::M_TDATA_W-1:36] == '0))
        else $error("padding bits set in result");

endmodule

bind arm_alu_shifter_flags aasf_checker u_aasf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/alu_flags_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_flags_checker
// Watches both stream channels of the ALU and predicts every result item from
// the accepted input items. It keeps its own NZCV flags and compares each
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module alu_flags_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // operand_a [31:0], operand_b [63:32]
    input  logic [aasf_pkg::S_TDATA_W-1:0]  s_tdata,
    // func [3:0], update_flags [4], update_carry [5]
    input  logic [aasf_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // value [31:0], flag_n [32], flag_z [33], flag_c [34], flag_v [35], zeros above
    input  logic [aasf_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                              mismatches,
    output int                              pending,
    output int                              results_checked,
    output logic [15:0]                     codes_seen
);

    import aasf_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        nzcv_t             flags;
    } alu_out_t;

    alu_out_t awaited_results[$];
    alu_out_t prediction;
    alu_out_t oldest;
    nzcv_t    flags_model;
    nzcv_t    got_flags;

    // value and flags after one operation, given the flags before it
    function automatic alu_out_t run_alu(
        input logic [FUNC_W-1:0] fn,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic              uf,
        input logic              uc,
        input nzcv_t             cur
    );
        alu_out_t           res;
        logic [DATA_W:0]    wide;
        logic [DATA_W:0]    subtrahend;
        logic [DATA_W-1:0]  r;
        logic [SHAMT_W-1:0] rot;
        logic               shc;
        logic               write_nz;
        nzcv_t              f;
        f        = cur;
        r        = '0;
        rot      = b[SHAMT_W-1:0];
        shc      = uf & uc;
        write_nz = uf;
        case (fn) inside
            FN_ADD, FN_ADC:
            begin
                wide = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, (fn == FN_ADC) && cur.c};
                r    = wide[DATA_W-1:0];
                if (uf)
                begin
                    f.c = wide[DATA_W];
                    f.v = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
                end
            end
            FN_SUB, FN_SBC:
            begin
                // sbc borrows one more when carry is clear
                subtrahend = {1'b0, b} + {{DATA_W{1'b0}}, (fn == FN_SBC) && !cur.c};
                r          = a - subtrahend[DATA_W-1:0];
                if (uf)
                begin
                    f.c = ({1'b0, a} >= subtrahend);
                    f.v = (a[31] ^ b[31]) & (a[31] ^ r[31]);
                end
            end
            FN_AND: r = a & b;
            FN_BIC: r = a & ~b;
            FN_EOR: r = a ^ b;
            FN_MOV: r = b;
            FN_MVN: r = ~b;
            FN_ORR: r = a | b;
            FN_MUL: r = a * b;
            FN_LSL:
            begin
                if (b == 0)
                    r = a;
                else if (b < 32)
                begin
                    r = a << rot;
                    if (shc)
                        f.c = a[32 - rot];
                end
                else if (shc)
                    f.c = (b == 32) && a[0];
            end
            FN_LSR:
            begin
                // zero amount means 32
                if (b != 0 && b < 32)
                begin
                    r = a >> rot;
                    if (shc)
                        f.c = a[rot - 1];
                end
                else if (shc)
                    f.c = (b == 0 || b == 32) && a[31];
            end
            FN_ASR:
            begin
                if (b != 0 && b < 32)
                begin
                    r = (a >> rot) | ({DATA_W{a[31]}} << (32 - rot));
                    if (shc)
                        f.c = a[rot - 1];
                end
                else
                begin
                    r = {DATA_W{a[31]}};
                    if (shc)
                        f.c = a[31];
                end
            end
            FN_ROR:
            begin
                // low byte zero leaves all alone, zero rotate index takes bit 31
                r = a;
                if (b[7:0] != 0)
                begin
                    if (rot == 0)
                    begin
                        if (shc)
                            f.c = a[31];
                    end
                    else
                    begin
                        r = (a >> rot) | (a << (32 - rot));
                        if (shc)
                            f.c = a[rot - 1];
                    end
                end
            end
            default:
            begin
                r        = '0;
                write_nz = 1'b0;
            end
        endcase
        if (write_nz)
        begin
            f.n = r[31];
            f.z = (r == 0);
        end
        res.value = r;
        res.flags = f;
        return res;
    endfunction

    // predict on input items, compare on result items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_results.delete();
            flags_model     = '0;
            mismatches      = 0;
            pending         = 0;
            results_checked = 0;
            codes_seen      = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                prediction  = run_alu(s_tuser[3:0], s_tdata[31:0], s_tdata[63:32],
                                      s_tuser[4], s_tuser[5], flags_model);
                flags_model = prediction.flags;
                awaited_results.push_back(prediction);
                codes_seen[s_tuser[3:0]] = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                got_flags = {m_tdata[32], m_tdata[33], m_tdata[34], m_tdata[35]};
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result item value %h nzcv %b",
                                 $realtime, m_tdata[31:0], got_flags);
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (m_tdata[31:0] !== oldest.value || m_tdata[32] !== oldest.flags.n ||
                        m_tdata[33] !== oldest.flags.z || m_tdata[34] !== oldest.flags.c ||
                        m_tdata[35] !== oldest.flags.v)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch, expected value %h nzcv %b,",
                                      " got value %h nzcv %b"},
                                     $realtime, oldest.value, oldest.flags,
                                     m_tdata[31:0], got_flags);
                    end
                end
            end
            pending = awaited_results.size();
        end
    end

endmodule

// ===== tb/tb_arm_alu_shifter_flags.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arm_alu_shifter_flags
// Drives a directed set of corner cases into the ALU, then random items and
// add/sub carry chains under three handshake pressure phases.
// A checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_arm_alu_shifter_flags;

    import aasf_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED        = 4'd15;
    localparam int                RANDOM_PER_PHASE = 175;
    localparam int                TAIL_CYCLES      = 8;
    localparam int                TIMEOUT_NS       = 2_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int          mismatches;
    int          pending;
    int          results_checked;
    logic [15:0] codes_seen;
    int          src_idle_pct;
    int          sink_idle_pct;

    arm_alu_shifter_flags dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    alu_flags_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .codes_seen      (codes_seen)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        m_tready = ($urandom_range(99) >= sink_idle_pct);
    end

    // one item in, with random idle cycles ahead of it
    task automatic send_op(
        input logic [FUNC_W-1:0] fn,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic              uf,
        input logic              uc
    );
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {b, a};
        s_tuser  = {uc, uf, fn};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // operand with a bias toward the edges
    function automatic logic [DATA_W-1:0] edgy_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'd1;
            default: return $urandom();
        endcase
    endfunction

    // shift amount around the interesting boundaries
    function automatic logic [DATA_W-1:0] shift_amount();
        case ($urandom_range(9))
            6:       return $urandom_range(255);
            7:       return $urandom() & 32'hFFFF_FFE0;
            8:       return $urandom();
            9:       return 32'd32 + $urandom_range(3);
            default: return $urandom_range(33);
        endcase
    endfunction

    initial
    begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        int                sent;
        int                chain_len;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        src_idle_pct  = 12;
        sink_idle_pct = 60;
        rst_n         = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed corner cases
        send_op(FN_ADD, 32'hFFFF_FFFF, 32'd1, 1'b1, 1'b0);
        send_op(FN_ADC, 32'd0, 32'd0, 1'b1, 1'b0);
        send_op(FN_ADD, 32'h7FFF_FFFF, 32'd1, 1'b1, 1'b0);
        send_op(FN_SUB, 32'd0, 32'd1, 1'b1, 1'b0);
        send_op(FN_SBC, 32'd5, 32'd3, 1'b1, 1'b0);
        send_op(FN_SUB, 32'h8000_0000, 32'd1, 1'b1, 1'b1);
        send_op(FN_SBC, 32'd7, 32'd7, 1'b1, 1'b0);
        send_op(FN_AND, 32'hFFFF_0000, 32'h0F0F_0F0F, 1'b0, 1'b1);
        send_op(FN_BIC, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 1'b1, 1'b0);
        send_op(FN_EOR, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b1);
        send_op(FN_MOV, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0);
        send_op(FN_MVN, 32'd0, 32'd0, 1'b1, 1'b0);
        send_op(FN_ORR, 32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0);
        send_op(FN_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_op(FN_LSL, 32'h8000_0001, 32'd0, 1'b1, 1'b1);
        send_op(FN_LSL, 32'd1, 32'd32, 1'b1, 1'b1);
        send_op(FN_LSL, 32'hFFFF_FFFF, 32'd33, 1'b1, 1'b1);
        send_op(FN_LSL, 32'h8000_0001, 32'd1, 1'b1, 1'b1);
        send_op(FN_LSR, 32'h8000_0000, 32'd0, 1'b1, 1'b1);
        send_op(FN_LSR, 32'hFFFF_FFFF, 32'd33, 1'b1, 1'b1);
        send_op(FN_ASR, 32'h8000_0000, 32'd0, 1'b1, 1'b1);
        send_op(FN_ASR, 32'h8000_0000, 32'd40, 1'b1, 1'b0);
        send_op(FN_ROR, 32'h1234_5678, 32'h0000_0100, 1'b1, 1'b1);
        send_op(FN_ROR, 32'h8000_0001, 32'h0000_0020, 1'b1, 1'b1);
        send_op(FN_ROR, 32'h0000_0001, 32'd8, 1'b1, 1'b1);
        send_op(FN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);

        // random phases, each drained before the next
        for (int phase = 0; phase < 3; phase++)
        begin
            s_tvalid = 1'b0;
            while (pending != 0)
                @(negedge clk);
            src_idle_pct  = (phase == 0) ? 12 : (phase == 1) ? 60 : 0;
            sink_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 12 : 0;
            sent = 0;
            while (sent < RANDOM_PER_PHASE)
            begin
                if ($urandom_range(3) == 0)
                begin
                    // multiword add or subtract: carry runs through the chain
                    fn        = $urandom_range(1) ? FN_ADD : FN_SUB;
                    chain_len = $urandom_range(4, 1);
                    send_op(fn, edgy_word(), edgy_word(), 1'b1, 1'($urandom_range(1)));
                    fn = (fn == FN_ADD) ? FN_ADC : FN_SBC;
                    repeat (chain_len)
                        send_op(fn, edgy_word(), edgy_word(), 1'b1, 1'($urandom_range(1)));
                    sent += chain_len + 1;
                end
                else
                begin
                    if ($urandom_range(39) == 0)
                        fn = FN_UNUSED;
                    else
                        fn = FUNC_W'($urandom_range(14));
                    a = edgy_word();
                    if (fn == FN_LSL || fn == FN_LSR || fn == FN_ASR || fn == FN_ROR)
                        b = shift_amount();
                    else
                        b = edgy_word();
                    send_op(fn, a, b, $urandom_range(3) != 0, 1'($urandom_range(1)));
                    sent++;
                end
            end
        end

        // drain and let the pipeline settle
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("checked %0d result items over %0d of 16 operation codes", results_checked,
                 $countones(codes_seen));
        $display("three back-pressure phases, directed shift and carry corners included");
        if (mismatches == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/aasf_pkg.sv
rtl/arm_alu_shifter_flags.sv
rtl/aasf_checker.sv
tb/alu_flags_checker.sv
tb/tb_arm_alu_shifter_flags.sv
